@@ rtl/vtm_pkg.sv @@
// Shared constants, codes and types for the voice and tone mixer.
`default_nettype none
package vtm_pkg;

   // Tone table entries per bank (power of two), tone numbers, voice gain scale (power of two)
   localparam int TABLE_DEPTH  = 256;
   localparam int TONE_COUNT   = 16;
   localparam int VOLUME_SCALE = 64;

   localparam int PTR_W     = $clog2(TABLE_DEPTH);
   localparam int LEN_W     = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W    = PTR_W + 1;
   localparam int RAM_DEPTH = 2 * TABLE_DEPTH;
   localparam int VOL_SHIFT = $clog2(VOLUME_SCALE);
   localparam int GAP_W     = 18;
   localparam int SAMPLE_W  = 16;
   localparam int PROD_W    = 24;

   localparam logic [7:0] TONE_OFF = 8'd255;

   // command codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_SET   = 2'd2;
   localparam logic [1:0] CMD_STOP  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_VOLUME     = 2'd0;
   localparam logic [1:0] CSR_MIN_PERIOD = 2'd1;
   localparam logic [1:0] CSR_STEP       = 2'd2;
   localparam logic [1:0] CSR_THRESHOLD  = 2'd3;

   localparam logic [6:0]  VOLUME_RST     = 7'd45;
   localparam logic [8:0]  MIN_PERIOD_RST = 9'd32;
   localparam logic [7:0]  STEP_RST       = 8'd4;
   localparam logic [15:0] THRESHOLD_RST  = 16'd1000;

   typedef struct packed {
      logic [8:0]  min_period;
      logic [7:0]  period_step;
      logic [15:0] gap_threshold;
   } cfg_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } ram_req_type;

   typedef struct packed {
      logic play;  // tone sample from the table goes into the sum
      logic gap;   // tone muted by the gap counter
   } tick_info_type;

endpackage
`default_nettype wire

@@ rtl/vtm_ram.sv @@
// Generic single-clock RAM, one write and one registered read port.
`default_nettype none
module vtm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/vtm_seq.sv @@
// Tone sequencer: bank, pointer, length and gap state, table read and write requests.
`default_nettype none
module vtm_seq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    accept,
   input  wire logic [1:0]              command,
   input  wire logic [7:0]              entry_index,
   input  wire logic [15:0]             entry_value,
   input  wire logic [7:0]              tone_number,
   input  wire vtm_pkg::cfg_type        cfg,
   output vtm_pkg::ram_req_type         ram_req,
   output vtm_pkg::tick_info_type       tick_info
);

   logic                       bank_ff, bank_in;
   logic [vtm_pkg::PTR_W-1:0]  ptr_ff, ptr_in;
   logic [vtm_pkg::LEN_W-1:0]  act_len_ff, act_len_in;
   logic [vtm_pkg::LEN_W-1:0]  pend_len_ff, pend_len_in;
   logic                       swap_ff, swap_in;
   logic [7:0]                 tone_ff, tone_in;
   logic [vtm_pkg::GAP_W-1:0]  gap_ff, gap_in;

   logic                       tone_on, low_tone, muted, wrap;
   logic [vtm_pkg::GAP_W-1:0]  gap_sum, thr_ext, thr2;
   logic [vtm_pkg::LEN_W-1:0]  ptr_inc, new_len;
   logic [15:0]                step_prod;
   logic [16:0]                len_sum;
   logic [31:0]                idx_ext;

   assign tone_on  = tone_ff < 8'(vtm_pkg::TONE_COUNT);
   assign low_tone = tone_ff < 8'(vtm_pkg::TONE_COUNT / 2);
   assign gap_sum  = low_tone ? gap_ff + vtm_pkg::GAP_W'(vtm_pkg::TONE_COUNT)
                                - vtm_pkg::GAP_W'(tone_ff)
                              : '0;
   assign thr_ext  = {2'b00, cfg.gap_threshold};
   assign thr2     = {1'b0, cfg.gap_threshold, 1'b0};
   assign muted    = gap_sum > thr_ext;

   assign ptr_inc  = vtm_pkg::LEN_W'(ptr_ff) + vtm_pkg::LEN_W'(1);
   assign wrap     = ptr_inc >= act_len_ff;

   assign step_prod = 16'(cfg.period_step) * 16'(tone_number);
   assign len_sum   = 17'(cfg.min_period) + 17'(step_prod);
   assign new_len   = (len_sum > 17'(vtm_pkg::TABLE_DEPTH))
                      ? vtm_pkg::LEN_W'(vtm_pkg::TABLE_DEPTH)
                      : len_sum[vtm_pkg::LEN_W-1:0];

   assign idx_ext = 32'(entry_index);

   always_comb begin
      bank_in     = bank_ff;
      ptr_in      = ptr_ff;
      act_len_in  = act_len_ff;
      pend_len_in = pend_len_ff;
      swap_in     = swap_ff;
      tone_in     = tone_ff;
      gap_in      = gap_ff;

      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = {~bank_ff, idx_ext[vtm_pkg::PTR_W-1:0]};
      ram_req.wr_data = entry_value;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = {bank_ff, ptr_ff};
      tick_info.play  = 1'b0;
      tick_info.gap   = 1'b0;

      if (accept) begin
         case (command)
            vtm_pkg::CMD_TICK: begin
               if (tone_on) begin
                  gap_in = gap_sum;
                  if (muted) begin
                     tick_info.gap = 1'b1;
                     if (gap_sum > thr2) begin
                        gap_in = '0;
                     end
                  end else begin
                     tick_info.play = 1'b1;
                     ram_req.rd_en  = 1'b1;
                     ptr_in = ptr_inc[vtm_pkg::PTR_W-1:0];
                     if (wrap) begin
                        ptr_in = '0;
                        if (swap_ff) begin
                           swap_in    = 1'b0;
                           bank_in    = ~bank_ff;
                           act_len_in = pend_len_ff;
                        end
                     end
                  end
               end
            end
            vtm_pkg::CMD_WRITE: begin
               ram_req.wr_en = idx_ext < 32'(vtm_pkg::TABLE_DEPTH);
            end
            vtm_pkg::CMD_SET: begin
               pend_len_in = new_len;
               swap_in     = 1'b1;
               if (!tone_on) begin
                  // nothing playing: new table takes over at once
                  bank_in    = ~bank_ff;
                  act_len_in = new_len;
                  ptr_in     = '0;
                  swap_in    = 1'b0;
               end
               tone_in = tone_number;
            end
            vtm_pkg::CMD_STOP: begin
               tone_in = vtm_pkg::TONE_OFF;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff     <= 1'b0;
         ptr_ff      <= '0;
         act_len_ff  <= '0;
         pend_len_ff <= '0;
         swap_ff     <= 1'b0;
         tone_ff     <= vtm_pkg::TONE_OFF;
         gap_ff      <= '0;
      end else begin
         bank_ff     <= bank_in;
         ptr_ff      <= ptr_in;
         act_len_ff  <= act_len_in;
         pend_len_ff <= pend_len_in;
         swap_ff     <= swap_in;
         tone_ff     <= tone_in;
         gap_ff      <= gap_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/voice_and_tone_audio_mixer.sv @@
// Voice and tone mixer: one result beat per sample tick. A sample tick registers its table
// RAM read and gain product in stage 1; the result register then raises rsp_tvalid. Other
// commands act at their accept edge. Throughput: one beat per cycle while the result side
// is not stalled, bounded by the single table read port used once per tick.
// Reset (synchronous): control state and pipeline valids clear, registers take defaults;
// the tone table RAM is not cleared.
`default_nettype none
module voice_and_tone_audio_mixer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // voice_sample[15:0], voice_valid[16], entry_index[24:17], entry_value[40:25],
   // tone_number[48:41]
   input  wire logic [55:0] req_tdata,
   // command[1:0]
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // mixed_sample[15:0]
   output logic [15:0]      rsp_tdata,
   // tone_gap[0]
   output logic [0:0]       rsp_tuser,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wr_data
);

   logic [6:0]  volume_ff;
   logic [8:0]  min_period_ff;
   logic [7:0]  step_ff;
   logic [15:0] threshold_ff;

   vtm_pkg::cfg_type       cfg;
   vtm_pkg::ram_req_type   ram_req;
   vtm_pkg::tick_info_type tick_info;

   logic accept, tick_acc, pipe_en, s1_adv;
   logic [vtm_pkg::SAMPLE_W-1:0] ram_rd_data;

   logic                               s1_valid_ff, s1_valid_in;
   logic signed [vtm_pkg::PROD_W-1:0]  s1_prod_ff, s1_prod_in;
   logic signed [vtm_pkg::PROD_W-1:0]  voice_prod;
   vtm_pkg::tick_info_type             s1_info_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [vtm_pkg::SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                         rsp_gap_ff;

   logic signed [vtm_pkg::PROD_W-1:0] biased, scaled;
   logic [vtm_pkg::SAMPLE_W-1:0]      tone_term;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff     <= vtm_pkg::VOLUME_RST;
         min_period_ff <= vtm_pkg::MIN_PERIOD_RST;
         step_ff       <= vtm_pkg::STEP_RST;
         threshold_ff  <= vtm_pkg::THRESHOLD_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            vtm_pkg::CSR_VOLUME:     volume_ff     <= csr_wr_data[6:0];
            vtm_pkg::CSR_MIN_PERIOD: min_period_ff <= csr_wr_data[8:0];
            vtm_pkg::CSR_STEP:       step_ff       <= csr_wr_data[7:0];
            vtm_pkg::CSR_THRESHOLD:  threshold_ff  <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.min_period    = min_period_ff;
   assign cfg.period_step   = step_ff;
   assign cfg.gap_threshold = threshold_ff;

   // handshake: s1 holds the tick waiting on its RAM data, rsp register behind it
   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign s1_adv     = !s1_valid_ff || pipe_en;
   assign req_tready = s1_adv;
   assign accept     = req_tvalid && s1_adv;
   assign tick_acc   = accept && (req_tuser == vtm_pkg::CMD_TICK);

   vtm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .command     (req_tuser),
      .entry_index (req_tdata[24:17]),
      .entry_value (req_tdata[40:25]),
      .tone_number (req_tdata[48:41]),
      .cfg         (cfg),
      .ram_req     (ram_req),
      .tick_info   (tick_info)
   );

   vtm_ram #(
      .WIDTH (vtm_pkg::SAMPLE_W),
      .DEPTH (vtm_pkg::RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_req.wr_en),
      .wr_addr (ram_req.wr_addr),
      .wr_data (ram_req.wr_data),
      .rd_en   (ram_req.rd_en),
      .rd_addr (ram_req.rd_addr),
      .rd_data (ram_rd_data)
   );

   // stage 1: voice gain product, sign-extended before the multiply
   assign voice_prod  = $signed(req_tdata[15:0]) * $signed({1'b0, volume_ff});
   assign s1_prod_in  = req_tdata[16] ? voice_prod : '0;
   assign s1_valid_in = s1_adv ? tick_acc : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tick_acc) begin
         s1_prod_ff <= s1_prod_in;
         s1_info_ff <= tick_info;
      end
   end

   // divide by the scale, truncating toward zero, then add the tone sample (wraps)
   assign biased    = s1_prod_ff + (s1_prod_ff[vtm_pkg::PROD_W-1]
                      ? vtm_pkg::PROD_W'(vtm_pkg::VOLUME_SCALE - 1)
                      : vtm_pkg::PROD_W'(0));
   assign scaled    = biased >>> vtm_pkg::VOL_SHIFT;
   assign tone_term = s1_info_ff.play ? ram_rd_data : '0;
   assign rsp_data_in  = scaled[vtm_pkg::SAMPLE_W-1:0] + tone_term;
   assign rsp_valid_in = pipe_en ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en && s1_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
         rsp_gap_ff  <= s1_info_ff.gap;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_gap_ff;

   // a full s1 behind a stalled result must block new beats
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("beat accepted while pipeline full");

   // table reads come only from accepted sample ticks
   a_read_tick: assert property (@(posedge clock) disable iff (reset)
      ram_req.rd_en |-> tick_acc)
      else $error("table read without a sample tick");

   a_rw_excl: assert property (@(posedge clock) disable iff (reset)
      !(ram_req.rd_en && ram_req.wr_en))
      else $error("table read and write in one cycle");

   a_tick_s1: assert property (@(posedge clock) disable iff (reset)
      tick_acc |=> s1_valid_ff)
      else $error("accepted tick did not reach stage 1");

endmodule
`default_nettype wire

@@ test/tb_voice_and_tone_audio_mixer.sv @@
// Self-checking stream testbench for the voice and tone audio mixer.
`timescale 1ns / 100ps
module tb_voice_and_tone_audio_mixer;

   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_BEATS = 1000;
   localparam int RANDOM_PHASES = 10;

   typedef struct {
      logic [15:0] mixed;
      logic        gap;
   } mix_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic [1:0]  req_tuser = vtm_pkg::CMD_TICK;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = vtm_pkg::CSR_VOLUME;
   logic [15:0] csr_wr_data = '0;

   // mixer state as the block should hold it
   logic [15:0] tone_ram [0:2*vtm_pkg::TABLE_DEPTH-1];
   int play_bank, play_ptr, play_len, next_len, tone_now, beep_count;
   bit swap_armed;
   int vol_reg, minp_reg, step_reg, thresh_reg;

   mix_beat_type mix_expect_q[$];
   int  mismatch_count = 0;
   int  stall_left = 0;
   int  quiet_cycles = 0;
   bit  req_idle_on = 1'b0;
   bit  rsp_idle_on = 1'b0;

   voice_and_tone_audio_mixer u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   task automatic reset_mixer_state();
      play_bank = 0;
      play_ptr = 0;
      play_len = 0;
      next_len = 0;
      swap_armed = 1'b0;
      tone_now = vtm_pkg::TONE_OFF;
      beep_count = 0;
      vol_reg = vtm_pkg::VOLUME_RST;
      minp_reg = vtm_pkg::MIN_PERIOD_RST;
      step_reg = vtm_pkg::STEP_RST;
      thresh_reg = vtm_pkg::THRESHOLD_RST;
   endtask

   // advance the mixer state by one accepted beat; ticks queue their expected output
   task automatic predict_mix(input logic [1:0] cmd, input logic [15:0] voice,
                              input logic vvalid, input logic [7:0] idx,
                              input logic [15:0] value, input logic [7:0] tone);
      int len;
      int sum;
      int ptr;
      mix_beat_type want;
      case (cmd)
         vtm_pkg::CMD_WRITE: begin
            if (idx < vtm_pkg::TABLE_DEPTH)
               tone_ram[(play_bank ^ 1) * vtm_pkg::TABLE_DEPTH + idx] = value;
         end
         vtm_pkg::CMD_SET: begin
            len = minp_reg + step_reg * tone;
            if (len > vtm_pkg::TABLE_DEPTH)
               len = vtm_pkg::TABLE_DEPTH;
            next_len = len;
            swap_armed = 1'b1;
            if (tone_now >= vtm_pkg::TONE_COUNT) begin
               // nothing playing: new table takes over at once
               play_bank ^= 1;
               play_len = len;
               play_ptr = 0;
               swap_armed = 1'b0;
            end
            tone_now = tone;
         end
         vtm_pkg::CMD_STOP: tone_now = vtm_pkg::TONE_OFF;
         default: begin
            sum = 0;
            want.gap = 1'b0;
            if (vvalid)
               sum = $signed(voice) * vol_reg / vtm_pkg::VOLUME_SCALE;
            if (tone_now < vtm_pkg::TONE_COUNT) begin
               if (tone_now < vtm_pkg::TONE_COUNT / 2)
                  beep_count = (beep_count + vtm_pkg::TONE_COUNT - tone_now) & 'h3FFFF;
               else
                  beep_count = 0;
               if (beep_count > thresh_reg) begin
                  want.gap = 1'b1;
                  if (beep_count > 2 * thresh_reg)
                     beep_count = 0;
               end else begin
                  ptr = play_ptr;
                  if (ptr >= vtm_pkg::TABLE_DEPTH)
                     ptr = 0;
                  sum += tone_ram[play_bank * vtm_pkg::TABLE_DEPTH + ptr];
                  play_ptr = ptr + 1;
                  if (play_ptr >= play_len) begin
                     play_ptr = 0;
                     if (swap_armed) begin
                        swap_armed = 1'b0;
                        play_bank ^= 1;
                        play_len = next_len;
                     end
                  end
               end
            end
            want.mixed = sum[15:0];
            mix_expect_q.push_back(want);
         end
      endcase
   endtask

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_beat(input logic [1:0] cmd, input logic [15:0] voice,
                            input logic vvalid, input logic [7:0] idx,
                            input logic [15:0] value, input logic [7:0] tone);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {7'd0, tone, value, idx, vvalid, voice};
      do
         @(posedge clock);
      while (!req_tready);
      predict_mix(cmd, voice, vvalid, idx, value, tone);
   endtask

   task automatic send_noise_fields(input logic [1:0] cmd, input logic [7:0] tone);
      send_beat(cmd, 16'($urandom), $urandom_range(0, 3) != 0, 8'($urandom),
                16'($urandom), tone);
   endtask

   // block must be idle before a register write
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (mix_expect_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= val[15:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         vtm_pkg::CSR_VOLUME:     vol_reg = val & 'h7F;
         vtm_pkg::CSR_MIN_PERIOD: minp_reg = val & 'h1FF;
         vtm_pkg::CSR_STEP:       step_reg = val & 'hFF;
         default:                 thresh_reg = val & 'hFFFF;
      endcase
      @(posedge clock);
   endtask

   task automatic load_idle_bank();
      logic [15:0] value;
      for (int i = 0; i < vtm_pkg::TABLE_DEPTH; i++) begin
         value = 16'($urandom);
         if (i == 0)
            value = 16'h8000;
         else if (i == vtm_pkg::TABLE_DEPTH - 1)
            value = 16'h7FFF;
         send_beat(vtm_pkg::CMD_WRITE, 16'($urandom), 1'($urandom_range(0, 1)), i[7:0],
                   value, 8'($urandom));
      end
   endtask

   // defaults out of reset, tone off, voice extremes and voice absent
   task automatic test_tone_off_voice();
      send_beat(vtm_pkg::CMD_TICK, 16'h7FFF, 1'b1, 8'h00, 16'h0000, 8'hFF);
      send_beat(vtm_pkg::CMD_TICK, 16'h8000, 1'b1, 8'hFF, 16'hFFFF, 8'h00);
      send_beat(vtm_pkg::CMD_TICK, 16'h1234, 1'b0, 8'h55, 16'hAAAA, 8'hAA);
      send_beat(vtm_pkg::CMD_STOP, 16'hFFFF, 1'b1, 8'hAA, 16'h5555, 8'h55);
   endtask

   // both banks get every entry before any tone reads them
   task automatic test_table_load();
      load_idle_bank();
      send_noise_fields(vtm_pkg::CMD_SET, 8'd0);
      load_idle_bank();
   endtask

   task automatic test_gap_and_swap();
      wait_drained();
      write_reg(vtm_pkg::CSR_VOLUME, 127);
      write_reg(vtm_pkg::CSR_MIN_PERIOD, 1);
      write_reg(vtm_pkg::CSR_STEP, 0);
      write_reg(vtm_pkg::CSR_THRESHOLD, 0);
      send_noise_fields(vtm_pkg::CMD_STOP, 8'd7);
      send_noise_fields(vtm_pkg::CMD_SET, 8'd0);
      // zero threshold mutes a low tone at once; gain above scale wraps
      send_beat(vtm_pkg::CMD_TICK, 16'h8000, 1'b1, 8'h00, 16'h0000, 8'h00);
      send_beat(vtm_pkg::CMD_TICK, 16'h7FFF, 1'b0, 8'h00, 16'h0000, 8'h00);
      // swap held until the one-entry period wraps
      send_noise_fields(vtm_pkg::CMD_SET, 8'(vtm_pkg::TONE_COUNT - 1));
      send_beat(vtm_pkg::CMD_TICK, 16'h7FFF, 1'b1, 8'h00, 16'h0000, 8'h00);
      send_noise_fields(vtm_pkg::CMD_TICK, 8'd0);
      send_noise_fields(vtm_pkg::CMD_SET, 8'(vtm_pkg::TONE_COUNT));
      send_noise_fields(vtm_pkg::CMD_TICK, 8'd0);
      send_noise_fields(vtm_pkg::CMD_SET, 8'd3);
      send_noise_fields(vtm_pkg::CMD_TICK, 8'd0);
      send_noise_fields(vtm_pkg::CMD_STOP, 8'd0);
      send_noise_fields(vtm_pkg::CMD_TICK, 8'd0);
   endtask

   task automatic test_zero_period();
      wait_drained();
      write_reg(vtm_pkg::CSR_VOLUME, 0);
      write_reg(vtm_pkg::CSR_MIN_PERIOD, 0);
      write_reg(vtm_pkg::CSR_THRESHOLD, 65535);
      send_noise_fields(vtm_pkg::CMD_SET, 8'd8);
      repeat (3) send_noise_fields(vtm_pkg::CMD_TICK, 8'd0);
      send_noise_fields(vtm_pkg::CMD_STOP, 8'd0);
   endtask

   task automatic test_saturated_period();
      wait_drained();
      write_reg(vtm_pkg::CSR_VOLUME, 64);
      write_reg(vtm_pkg::CSR_MIN_PERIOD, 511);
      write_reg(vtm_pkg::CSR_STEP, 255);
      send_noise_fields(vtm_pkg::CMD_SET, 8'(vtm_pkg::TONE_COUNT - 1));
      repeat (2) send_noise_fields(vtm_pkg::CMD_TICK, 8'd0);
      send_noise_fields(vtm_pkg::CMD_SET, 8'd255);
      send_noise_fields(vtm_pkg::CMD_TICK, 8'd0);
   endtask

   task automatic pick_config();
      case ($urandom_range(0, 5))
         0: write_reg(vtm_pkg::CSR_VOLUME, 0);
         1: write_reg(vtm_pkg::CSR_VOLUME, 64);
         2: write_reg(vtm_pkg::CSR_VOLUME, 127);
         default: write_reg(vtm_pkg::CSR_VOLUME, $urandom_range(0, 64));
      endcase
      case ($urandom_range(0, 7))
         0: write_reg(vtm_pkg::CSR_MIN_PERIOD, 0);
         1: write_reg(vtm_pkg::CSR_MIN_PERIOD, 1);
         2: write_reg(vtm_pkg::CSR_MIN_PERIOD, 256);
         3: write_reg(vtm_pkg::CSR_MIN_PERIOD, 511);
         default: write_reg(vtm_pkg::CSR_MIN_PERIOD, $urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 4))
         0: write_reg(vtm_pkg::CSR_STEP, 0);
         1: write_reg(vtm_pkg::CSR_STEP, 255);
         default: write_reg(vtm_pkg::CSR_STEP, $urandom_range(0, 6));
      endcase
      case ($urandom_range(0, 5))
         0: write_reg(vtm_pkg::CSR_THRESHOLD, 0);
         1: write_reg(vtm_pkg::CSR_THRESHOLD, 65535);
         2: write_reg(vtm_pkg::CSR_THRESHOLD, $urandom_range(0, 65535));
         default: write_reg(vtm_pkg::CSR_THRESHOLD, $urandom_range(0, 400));
      endcase
   endtask

   function automatic logic [7:0] pick_tone();
      case ($urandom_range(0, 9))
         7: return 8'($urandom_range(vtm_pkg::TONE_COUNT, 255));
         8: return 8'd255;
         9: return 8'($urandom);
         default: return 8'($urandom_range(0, vtm_pkg::TONE_COUNT - 1));
      endcase
   endfunction

   // episodes: load some entries, set a tone, play it with a little noise mixed in
   task automatic test_random_traffic();
      int sent;
      int quota;
      int n;
      logic [1:0] cmd;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         pick_config();
         req_idle_on = (phase < RANDOM_PHASES - 2) && $urandom_range(0, 1);
         rsp_idle_on = (phase < RANDOM_PHASES - 2) && $urandom_range(0, 1);
         quota = RANDOM_BEATS / RANDOM_PHASES;
         sent = 0;
         while (sent < quota) begin
            n = $urandom_range(0, 24);
            for (int i = 0; i < n; i++)
               send_noise_fields(vtm_pkg::CMD_WRITE, 8'($urandom));
            send_noise_fields(vtm_pkg::CMD_SET, pick_tone());
            sent += n + 1;
            n = $urandom_range(4, 60);
            for (int i = 0; i < n; i++) begin
               case ($urandom_range(0, 99))
                  0, 1, 2, 3, 4, 5, 6: cmd = vtm_pkg::CMD_WRITE;
                  7, 8, 9, 10:          cmd = vtm_pkg::CMD_SET;
                  11, 12, 13:           cmd = vtm_pkg::CMD_STOP;
                  default:              cmd = vtm_pkg::CMD_TICK;
               endcase
               send_noise_fields(cmd, (cmd == vtm_pkg::CMD_SET) ? pick_tone() : 8'($urandom));
            end
            sent += n;
         end
      end
   endtask

   // result side: random ready stalls and field-by-field compare
   always @(posedge clock) begin : rsp_side
      mix_beat_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (mix_expect_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result beat, expected none actual %h/%b",
                        $time, rsp_tdata, rsp_tuser);
            end else begin
               want = mix_expect_q.pop_front();
               if (rsp_tdata !== want.mixed) begin
                  mismatch_count++;
                  $display("%0t: mixed_sample expected %h actual %h",
                           $time, want.mixed, rsp_tdata);
               end
               if (rsp_tuser[0] !== want.gap) begin
                  mismatch_count++;
                  $display("%0t: tone_gap expected %b actual %b",
                           $time, want.gap, rsp_tuser[0]);
               end
            end
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(0, 10);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset_mixer_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_tone_off_voice();
      test_table_load();
      test_gap_and_swap();
      test_zero_period();
      test_saturated_period();
      test_random_traffic();
      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ voice_and_tone_audio_mixer.f @@
rtl/vtm_pkg.sv
rtl/vtm_ram.sv
rtl/vtm_seq.sv
rtl/voice_and_tone_audio_mixer.sv
test/tb_voice_and_tone_audio_mixer.sv
